// ===== hdl/encoder_pid_motor_position_controller_macros.svh =====
// Assertion macros shared by the checker of the motor position controller.
`ifndef ENCODER_PID_MOTOR_POSITION_CONTROLLER_MACROS_SVH
`define ENCODER_PID_MOTOR_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EPMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define EPMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/epmc_pkg.sv =====
// Types, constants and codes shared by the motor position controller.
`default_nettype none

package epmc_pkg;

  // Duty resolution of the drive outputs.
  localparam int PWM_BITS = 10;

  localparam int DIV_W     = 53;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [19:0] MICRO = 20'd1000000;
  // Each PID term saturates at this magnitude.
  localparam logic [47:0] TERM_LIM = 48'h8000_0000_0000;
  // Smallest gain times integral product whose quotient by one million exceeds the limit.
  localparam logic [95:0] I_SAT_BOUND = (96'(TERM_LIM) + 96'd1) * 96'(MICRO);
  localparam logic [16:0] DUTY_CAP = 17'((1 << PWM_BITS) - 1);
  localparam logic [7:0]  DUTY_SAT = 8'd255;

  // One million is 64 times this odd factor; the shift by six is taken first.
  localparam logic [13:0] MICRO_ODD = 14'd15625;
  // Floor of 2^64 / 15625, split into a low word and a high part.
  localparam logic [31:0] RECIP_LO  = 32'hE82D_7B63;
  localparam logic [18:0] RECIP_HI  = 19'h4_31BD;

  localparam logic [CNT_W-1:0] DERIV_DIV_LEN = 7'd53;

  typedef enum logic [1:0] {
    FUNC_EDGE   = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_PRESET = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_GOAL     = 3'd3,
    CFG_FLOOR    = 3'd4,
    CFG_CEILING  = 3'd5,
    CFG_SEP_EN   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    func_e              func;
    logic               b_level;
    logic [23:0]        elapsed_us;
    logic signed [31:0] preset_value;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         in1_drive;
    logic [9:0]         in2_drive;
    logic [9:0]         enable_duty;
    logic               reached;
    logic signed [31:0] position_now;
  } out_word_t;

  typedef enum logic [3:0] {
    MUL_E_EL  = 4'd0,
    MUL_DE_US = 4'd1,
    MUL_GP_E  = 4'd2,
    MUL_GD_LO = 4'd3,
    MUL_GD_HI = 4'd4,
    MUL_GI_LO = 4'd5,
    MUL_GI_HI = 4'd6,
    MUL_NL_RL = 4'd7,
    MUL_NL_RH = 4'd8,
    MUL_NH_RL = 4'd9,
    MUL_NH_RH = 4'd10,
    MUL_Q_ODD = 4'd11
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_LOAD  = 2'd1,
    ACC_ADD24 = 2'd2,
    ACC_ADD32 = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    RACC_HOLD  = 2'd0,
    RACC_LOAD  = 2'd1,
    RACC_ADD   = 2'd2,
    RACC_ADD32 = 2'd3
  } racc_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_INC, ST_DLD, ST_PST, ST_DWAIT, ST_DLO,
    ST_DHI, ST_DSUM, ST_DFIN, ST_ISUM, ST_RLL, ST_RLH, ST_RHL, ST_RHH,
    ST_RADD, ST_RQ, ST_RFIX, ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic     take;
    mul_sel_e mul_sel;
    logic     integ_upd;
    logic     div_start;
    logic     store_p;
    acc_op_e  acc_op;
    racc_op_e racc_op;
    logic     store_d;
    logic     store_i;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic item_tick;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/epmc_if.sv =====
// Valid/ready channel interfaces for input and result words.
`default_nettype none

interface epmc_in_if import epmc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface epmc_out_if import epmc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/epmc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module epmc_div import epmc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CNT_W-1:0] len_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [23:0]      divisor_i,
  output logic                  busy_o,
  output logic [DIV_W-1:0]      quotient_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [23:0]      rem_q, rem_d;
  logic [23:0]      den_q, den_d;
  logic [DIV_W-1:0] dq_q, dq_d;
  logic [24:0]      shifted;
  logic             fits;

  // One shift-and-subtract step; dividend bits leave at the top, quotient bits enter at the bottom.
  always_comb begin
    shifted = {rem_q, dq_q[DIV_W-1]};
    fits    = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    dq_d    = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = len_i;
      rem_d  = 24'd0;
      den_d  = divisor_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? 24'(shifted - {1'b0, den_q}) : shifted[23:0];
      dq_d  = {dq_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dq_q  <= dq_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// ===== hdl/epmc_dp.sv =====
// Datapath: registers, shared multiplier, accumulator, divider and drive logic.
`default_nettype none

module epmc_dp import epmc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_word_t              item_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_stat_t                   stat_o,
  output out_word_t                  out_word_o
);

  // Magnitude helpers and sign application.
  function automatic logic [47:0] sat_lim(input logic [95:0] v);
    sat_lim = (v > 96'(TERM_LIM)) ? TERM_LIM : v[47:0];
  endfunction

  function automatic logic signed [48:0] signed_term(input logic [47:0] mag, input logic neg);
    logic signed [48:0] m;
    m = $signed({1'b0, mag});
    signed_term = neg ? -m : m;
  endfunction

  // Configuration registers.
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, goal_q;
  logic [9:0]         floor_q, ceil_q;
  logic               sep_en_q;

  // Architectural state.
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        prev_err_q;
  logic signed [63:0] integ_q;
  logic               reached_q, reached_d;
  logic [9:0]         held_in1_q, held_in2_q, held_en_q;
  logic [9:0]         new_in1, new_in2, new_en;
  out_word_t          out_q, out_d;

  // Working registers of a tick.
  logic signed [31:0] err_q, err_now;
  logic signed [32:0] de_q;
  logic [23:0]        el_q;
  logic [65:0]        prod_q, prod_d;
  logic [95:0]        acc_q;
  logic [79:0]        racc_q;
  logic [47:0]        i_mag_q;
  logic signed [48:0] p_term_q, d_term_q, i_term;
  logic               i_big_q;

  logic [32:0]        mul_a, mul_b;
  logic [31:0]        e_mag, gp_mag, gi_mag, gd_mag;
  logic [32:0]        de_mag;
  logic [63:0]        integ_mag;
  logic               div_busy;
  logic [DIV_W-1:0]   quot;
  logic [31:0]        i_rem;
  logic               i_fix;
  logic [64:0]        inc_mag;
  logic signed [64:0] inc_s, integ_sum;
  logic               deriv_big;
  logic [47:0]        d_mag;
  logic signed [50:0] u;
  logic [50:0]        u_mag;
  logic [7:0]         duty8;
  logic [9:0]         duty_cl, duty_fin;
  logic               rev, e_zero;

  assign err_now = $signed(pos_q - goal_q);

  assign e_mag     = err_q[31] ? 32'(-err_q) : err_q;
  assign de_mag    = de_q[32] ? 33'(-de_q) : de_q;
  assign gp_mag    = gain_p_q[31] ? 32'(-gain_p_q) : gain_p_q;
  assign gi_mag    = gain_i_q[31] ? 32'(-gain_i_q) : gain_i_q;
  assign gd_mag    = gain_d_q[31] ? 32'(-gain_d_q) : gain_d_q;
  assign integ_mag = integ_q[63] ? 64'(-integ_q) : integ_q;
  assign deriv_big = |quot[52:48];

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_E_EL: begin
        mul_a = {1'b0, e_mag};
        mul_b = {9'd0, el_q};
      end
      MUL_DE_US: begin
        mul_a = de_mag;
        mul_b = {13'd0, MICRO};
      end
      MUL_GP_E: begin
        mul_a = {1'b0, gp_mag};
        mul_b = {1'b0, e_mag};
      end
      MUL_GD_LO: begin
        mul_a = {1'b0, gd_mag};
        mul_b = {9'd0, quot[23:0]};
      end
      MUL_GD_HI: begin
        mul_a = {1'b0, gd_mag};
        mul_b = {9'd0, quot[47:24]};
      end
      MUL_GI_LO: begin
        mul_a = {1'b0, gi_mag};
        mul_b = {1'b0, integ_mag[31:0]};
      end
      MUL_GI_HI: begin
        mul_a = {1'b0, gi_mag};
        mul_b = {1'b0, integ_mag[63:32]};
      end
      MUL_NL_RL: begin
        mul_a = {1'b0, acc_q[37:6]};
        mul_b = {1'b0, RECIP_LO};
      end
      MUL_NL_RH: begin
        mul_a = {1'b0, acc_q[37:6]};
        mul_b = {14'd0, RECIP_HI};
      end
      MUL_NH_RL: begin
        mul_a = {4'd0, acc_q[66:38]};
        mul_b = {1'b0, RECIP_LO};
      end
      MUL_NH_RH: begin
        mul_a = {4'd0, acc_q[66:38]};
        mul_b = {14'd0, RECIP_HI};
      end
      MUL_Q_ODD: begin
        mul_a = {1'b0, racc_q[63:32]};
        mul_b = {19'd0, MICRO_ODD};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Saturating update of the integral.
  always_comb begin
    inc_mag   = {9'd0, prod_q[55:0]};
    inc_s     = err_q[31] ? -$signed(inc_mag) : $signed(inc_mag);
    integ_sum = $signed({integ_q[63], integ_q}) + inc_s;
  end

  // Derivative division by the elapsed time.
  epmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .len_i      (DERIV_DIV_LEN),
    .dividend_i (prod_q[DIV_W-1:0]),
    .divisor_i  (el_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // The reciprocal estimate of the integral quotient is low by at most one;
  // the remainder, which fits in one word, tells when to add it back.
  assign i_rem = acc_q[37:6] - prod_q[31:0];
  assign i_fix = (i_rem >= {18'd0, MICRO_ODD});

  assign d_mag  = (deriv_big && (gain_d_q != 32'sd0)) ? TERM_LIM : sat_lim(acc_q);
  assign i_term = signed_term(i_big_q ? TERM_LIM : i_mag_q, gain_i_q[31] ^ integ_q[63]);

  // Sum of terms, duty clamping and bridge drive.
  always_comb begin
    u       = 51'(p_term_q) + 51'(i_term) + 51'(d_term_q);
    u_mag   = u[50] ? 51'(-u) : 51'(u);
    duty8   = (|u_mag[50:24]) ? DUTY_SAT : u_mag[23:16];
    if ({2'b0, duty8} < floor_q) begin
      duty_cl = floor_q;
    end else if ({2'b0, duty8} > ceil_q) begin
      duty_cl = ceil_q;
    end else begin
      duty_cl = {2'b0, duty8};
    end
    duty_fin = ({7'd0, duty_cl} > DUTY_CAP) ? DUTY_CAP[9:0] : duty_cl;
    rev      = u[50];
    e_zero   = (err_q == 32'sd0);
    if (sep_en_q) begin
      new_en  = duty_fin;
      new_in1 = (!e_zero && !rev) ? 10'd1 : 10'd0;
      new_in2 = (!e_zero && rev) ? 10'd1 : 10'd0;
    end else begin
      new_en  = 10'd0;
      new_in1 = (!e_zero && !rev) ? duty_fin : 10'd0;
      new_in2 = (!e_zero && rev) ? duty_fin : 10'd0;
    end
  end

  // Position and reached flag for the items handled at acceptance, and the reached flag at the end of a tick.
  always_comb begin
    pos_d     = pos_q;
    reached_d = reached_q;
    if (cmd_i.take) begin
      unique case (item_i.func)
        FUNC_EDGE:   pos_d = item_i.b_level ? pos_q - 32'd1 : pos_q + 32'd1;
        FUNC_TICK:   pos_d = pos_q;
        FUNC_PRESET: pos_d = item_i.preset_value;
        FUNC_CLEAR:  reached_d = 1'b0;
      endcase
    end else if (cmd_i.finish) begin
      reached_d = e_zero;
    end
  end

  // Result word: held drive on plain items, fresh drive at the end of a tick.
  always_comb begin
    out_d = out_q;
    if (cmd_i.finish) begin
      out_d = '{in1_drive: new_in1, in2_drive: new_in2, enable_duty: new_en,
                reached: e_zero, position_now: pos_q};
    end else if (cmd_i.take && (item_i.func != FUNC_TICK)) begin
      out_d = '{in1_drive: held_in1_q, in2_drive: held_in2_q, enable_duty: held_en_q,
                reached: reached_d, position_now: pos_d};
    end
  end

  // Configuration and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      goal_q     <= '0;
      floor_q    <= 10'd0;
      ceil_q     <= 10'd255;
      sep_en_q   <= 1'b1;
      pos_q      <= '0;
      prev_err_q <= '0;
      integ_q    <= '0;
      reached_q  <= 1'b0;
      held_in1_q <= '0;
      held_in2_q <= '0;
      held_en_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GAIN_P:  gain_p_q <= cfg_data_i;
          CFG_GAIN_I:  gain_i_q <= cfg_data_i;
          CFG_GAIN_D:  gain_d_q <= cfg_data_i;
          CFG_GOAL:    goal_q   <= cfg_data_i;
          CFG_FLOOR:   floor_q  <= cfg_data_i[9:0];
          CFG_CEILING: ceil_q   <= cfg_data_i[9:0];
          CFG_SEP_EN:  sep_en_q <= cfg_data_i[0];
          default:     ;
        endcase
      end
      pos_q     <= pos_d;
      reached_q <= reached_d;
      if (cmd_i.integ_upd) begin
        if (integ_sum[64] != integ_sum[63]) begin
          integ_q <= integ_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          integ_q <= integ_sum[63:0];
        end
      end
      if (cmd_i.finish) begin
        prev_err_q <= err_q;
        held_in1_q <= new_in1;
        held_in2_q <= new_in2;
        held_en_q  <= new_en;
      end
    end
  end

  // Working registers of a tick.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    out_q  <= out_d;
    if (cmd_i.take) begin
      err_q <= err_now;
      de_q  <= {err_now[31], err_now} - $signed({prev_err_q[31], prev_err_q});
      el_q  <= (item_i.elapsed_us == 24'd0) ? 24'd1 : item_i.elapsed_us;
    end
    if (cmd_i.store_p) begin
      p_term_q <= signed_term(sat_lim({30'd0, prod_q}), gain_p_q[31] ^ err_q[31]);
    end
    if (cmd_i.store_d) begin
      d_term_q <= signed_term(d_mag, gain_d_q[31] ^ de_q[32]);
    end
    if (cmd_i.store_i) begin
      i_big_q <= acc_q >= I_SAT_BOUND;
      i_mag_q <= racc_q[79:32] + 48'(i_fix);
    end
    unique case (cmd_i.acc_op)
      ACC_HOLD:  acc_q <= acc_q;
      ACC_LOAD:  acc_q <= {30'd0, prod_q};
      ACC_ADD24: acc_q <= acc_q + ({30'd0, prod_q} << 24);
      ACC_ADD32: acc_q <= acc_q + ({30'd0, prod_q} << 32);
    endcase
    // Reciprocal product, kept from bit 32 upward.
    unique case (cmd_i.racc_op)
      RACC_HOLD:  racc_q <= racc_q;
      RACC_LOAD:  racc_q <= {46'd0, prod_q[65:32]};
      RACC_ADD:   racc_q <= racc_q + {14'd0, prod_q};
      RACC_ADD32: racc_q <= racc_q + {prod_q[47:0], 32'd0};
    endcase
  end

  assign stat_o.div_busy  = div_busy;
  assign stat_o.item_tick = (item_i.func == FUNC_TICK);
  assign out_word_o       = out_q;

endmodule

`default_nettype wire

// ===== hdl/epmc_ctrl.sv =====
// Controller: sequences a control tick and owns the handshakes.
`default_nettype none

module epmc_ctrl import epmc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        take;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_E_EL;
    cmd_o.acc_op  = ACC_HOLD;
    cmd_o.racc_op = RACC_HOLD;
    cmd_o.take    = take;
    unique case (state_q)
      ST_IDLE: begin
        if (take && stat_i.item_tick) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.mul_sel = MUL_E_EL;
        state_d       = ST_INC;
      end
      ST_INC: begin
        cmd_o.integ_upd = 1'b1;
        cmd_o.mul_sel   = MUL_DE_US;
        state_d         = ST_DLD;
      end
      ST_DLD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.mul_sel   = MUL_GP_E;
        state_d         = ST_PST;
      end
      ST_PST: begin
        cmd_o.store_p = 1'b1;
        state_d       = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!stat_i.div_busy) begin
          state_d = ST_DLO;
        end
      end
      ST_DLO: begin
        cmd_o.mul_sel = MUL_GD_LO;
        state_d       = ST_DHI;
      end
      ST_DHI: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_GD_HI;
        state_d       = ST_DSUM;
      end
      ST_DSUM: begin
        cmd_o.acc_op  = ACC_ADD24;
        cmd_o.mul_sel = MUL_GI_LO;
        state_d       = ST_DFIN;
      end
      ST_DFIN: begin
        cmd_o.store_d = 1'b1;
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_GI_HI;
        state_d       = ST_ISUM;
      end
      ST_ISUM: begin
        cmd_o.acc_op = ACC_ADD32;
        state_d      = ST_RLL;
      end
      // Integral quotient by one million through four reciprocal partial products.
      ST_RLL: begin
        cmd_o.mul_sel = MUL_NL_RL;
        state_d       = ST_RLH;
      end
      ST_RLH: begin
        cmd_o.racc_op = RACC_LOAD;
        cmd_o.mul_sel = MUL_NL_RH;
        state_d       = ST_RHL;
      end
      ST_RHL: begin
        cmd_o.racc_op = RACC_ADD;
        cmd_o.mul_sel = MUL_NH_RL;
        state_d       = ST_RHH;
      end
      ST_RHH: begin
        cmd_o.racc_op = RACC_ADD;
        cmd_o.mul_sel = MUL_NH_RH;
        state_d       = ST_RADD;
      end
      ST_RADD: begin
        cmd_o.racc_op = RACC_ADD32;
        state_d       = ST_RQ;
      end
      ST_RQ: begin
        cmd_o.mul_sel = MUL_Q_ODD;
        state_d       = ST_RFIX;
      end
      ST_RFIX: begin
        cmd_o.store_i = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output word valid: set when a result is loaded, cleared when taken.
  always_comb begin
    if (cmd_o.finish || (take && !stat_i.item_tick)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/encoder_pid_motor_position_controller.sv =====
// Top level of the encoder-fed PID motor position controller.
// Edge, preset and clear words give a result word that is valid the next cycle.
// A control tick runs its states, among them the 53-step bit-serial derivative division;
// the input opens again in the cycle that its result word is taken.
// A new word is taken only while the controller is idle and the result register is free.
// Active-low async reset clears position, integral, flags, held drive, gains and goal.
`default_nettype none

module encoder_pid_motor_position_controller import epmc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  epmc_in_if.sink                    in_i,
  epmc_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t out_word;
  logic      in_ready;
  logic      out_valid;

  epmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  epmc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_i.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_word;

endmodule

`default_nettype wire

// ===== hdl/epmc_chk.sv =====
// Port-level checker for the motor position controller and its bind.
`default_nettype none
`include "encoder_pid_motor_position_controller_macros.svh"

module epmc_chk import epmc_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire func_e in_func,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire logic  out_reached
);

  logic in_take;
  assign in_take = in_valid && in_ready;

  // A stalled result word stays offered.
  `EPMC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  // A word is taken only when the result register is free or being emptied.
  `EPMC_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, in_take, !out_valid || out_ready, "input taken over a pending result")

  // Plain items give their result word on the next cycle.
  `EPMC_ASSERT_NXT(a_plain_result, clk_i, rst_ni, in_take && (in_func != FUNC_TICK), out_valid, "missing result after a plain item")

  // A control tick closes the input once it is taken.
  `EPMC_ASSERT_NXT(a_tick_busy, clk_i, rst_ni, in_take && (in_func == FUNC_TICK), !in_ready, "input open during a tick")

  // A clear item reports the flag as dropped.
  `EPMC_ASSERT_NXT(a_clear_flag, clk_i, rst_ni, in_take && (in_func == FUNC_CLEAR), out_valid && !out_reached, "reached flag not cleared")

endmodule

bind encoder_pid_motor_position_controller epmc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_func     (in_i.data.func),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_reached (out_o.data.reached)
);

`default_nettype wire

// ===== tb/tb_encoder_pid_motor_position_controller.sv =====
// Self-checking testbench for the encoder-fed PID motor position controller.
`timescale 1ns / 1ps

module tb_encoder_pid_motor_position_controller;
  import epmc_pkg::*;

  localparam int          CLK_HALF   = 5;
  localparam int          MAX_CYCLES = 2_000_000;
  localparam int          IDLE_WAIT  = 160;
  localparam logic [127:0] SAT_MAG   = 128'h8000_0000_0000;
  localparam longint      ONE_MHZ_US = 1000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  epmc_in_if  in_ch ();
  epmc_out_if out_ch ();

  encoder_pid_motor_position_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Controller model state and register copies.
  logic signed [31:0] kp, ki, kd, goal;
  logic [9:0]         duty_lo, duty_hi;
  logic               sep_en;
  logic [31:0]        pos_cnt, last_err;
  longint             err_sum;
  logic               at_goal;
  logic [9:0]         drv_in1, drv_in2, drv_en;

  out_word_t expected_words[$];
  int        mismatches;
  int        words_sent, words_checked, ticks_sent;
  longint    cycle_cnt;
  bit        idle_en;
  int        sink_stall;

  // Clock.
  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("encoder_pid_motor_position_controller test failed");
      $finish;
    end
  end

  function automatic logic [127:0] magnitude(input longint x);
    logic signed [127:0] w;
    w = x;
    if (w < 0) w = -w;
    return w;
  endfunction

  // Unsigned product limited to the term saturation level.
  function automatic logic [127:0] sat_mul(input logic [127:0] a, input logic [127:0] b);
    logic [127:0] p;
    p = a * b;
    return (p > SAT_MAG) ? SAT_MAG : p;
  endfunction

  function automatic longint signed_term(input longint a, input longint b);
    logic [127:0] m;
    m = sat_mul(magnitude(a), magnitude(b));
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Integral term: gain times accumulated error, divided by one million.
  function automatic longint integral_term(input longint g, input longint acc);
    logic [127:0] gm, am, t;
    gm = magnitude(g);
    am = magnitude(acc);
    t = sat_mul(gm, am / ONE_MHZ_US) + (gm * (am % ONE_MHZ_US)) / ONE_MHZ_US;
    if (t > SAT_MAG) t = SAT_MAG;
    return ((g < 0) != (acc < 0)) ? -longint'(t) : longint'(t);
  endfunction

  // One PID step of the controller.
  task automatic pid_step(input logic [23:0] el_in);
    longint e, el, inc, de, deriv, u;
    logic signed [65:0] s;
    logic [127:0] duty;
    begin
      el = (el_in == 0) ? 1 : el_in;
      e = longint'($signed(pos_cnt - goal));
      inc = e * el;
      s = err_sum;
      s = s + inc;
      if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF) err_sum = 64'h7FFF_FFFF_FFFF_FFFF;
      else if (s < -66'sh0_8000_0000_0000_0000) err_sum = 64'h8000_0000_0000_0000;
      else err_sum = s[63:0];
      de = e - longint'($signed(last_err));
      deriv = (de * ONE_MHZ_US) / el;
      u = signed_term(kp, e) + integral_term(ki, err_sum) + signed_term(kd, deriv);
      duty = magnitude(u) >> 16;
      if (duty > 255) duty = 255;
      if (duty < duty_lo) duty = duty_lo;
      else if (duty > duty_hi) duty = duty_hi;
      if (duty > 1023) duty = 1023;
      drv_in1 = '0;
      drv_in2 = '0;
      if (sep_en) begin
        drv_en = duty[9:0];
        if (e != 0) begin
          if (u < 0) drv_in2 = 10'd1; else drv_in1 = 10'd1;
        end
      end else begin
        drv_en = '0;
        if (e != 0) begin
          if (u < 0) drv_in2 = duty[9:0]; else drv_in1 = duty[9:0];
        end
      end
      at_goal = (e == 0);
      last_err = e[31:0];
    end
  endtask

  // Apply one accepted word to the model and queue the expected result.
  task automatic predict_word(input in_word_t w);
    out_word_t r;
    begin
      case (w.func)
        FUNC_EDGE:   pos_cnt = w.b_level ? pos_cnt - 1 : pos_cnt + 1;
        FUNC_TICK:   pid_step(w.elapsed_us);
        FUNC_PRESET: pos_cnt = w.preset_value;
        default:     at_goal = 1'b0;
      endcase
      r.in1_drive = drv_in1;
      r.in2_drive = drv_in2;
      r.enable_duty = drv_en;
      r.reached = at_goal;
      r.position_now = pos_cnt;
      expected_words.push_back(r);
    end
  endtask

  // Send one word, with a random gap before it when idling is on.
  task automatic send_word(input func_e f, input logic b, input logic [23:0] el,
                           input logic [31:0] pv);
    int gap;
    in_word_t w;
    begin
      gap = idle_en ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
      w.func = f;
      w.b_level = b;
      w.elapsed_us = el;
      w.preset_value = pv;
      @(negedge clk_i);
      in_ch.valid <= 1'b1;
      in_ch.data <= w;
      do @(posedge clk_i); while (!in_ch.ready);
      predict_word(w);
      words_sent++;
      if (f == FUNC_TICK) ticks_sent++;
    end
  endtask

  // Hold off until every expected word has arrived and the controller is idle.
  task automatic drain;
    begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clk_i);
      repeat (5) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= val;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      case (idx)
        CFG_GAIN_P:  kp = val;
        CFG_GAIN_I:  ki = val;
        CFG_GAIN_D:  kd = val;
        CFG_GOAL:    goal = val;
        CFG_FLOOR:   duty_lo = val[9:0];
        CFG_CEILING: duty_hi = val[9:0];
        default:     sep_en = val[0];
      endcase
    end
  endtask

  task automatic write_all(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                           input logic [31:0] g, input logic [9:0] lo, input logic [9:0] hi,
                           input logic sep);
    begin
      drain();
      write_reg(CFG_GAIN_P, p);
      write_reg(CFG_GAIN_I, i);
      write_reg(CFG_GAIN_D, d);
      write_reg(CFG_GOAL, g);
      write_reg(CFG_FLOOR, {22'd0, lo});
      write_reg(CFG_CEILING, {22'd0, hi});
      write_reg(CFG_SEP_EN, {31'd0, sep});
    end
  endtask

  // Result sink: random stalls on ready, then a field-by-field compare.
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_word_t exp_w, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      sink_stall <= idle_en ? $urandom_range(0, 5) : 0;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", got);
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        if (got.in1_drive !== exp_w.in1_drive || got.in2_drive !== exp_w.in2_drive ||
            got.enable_duty !== exp_w.enable_duty || got.reached !== exp_w.reached ||
            got.position_now !== exp_w.position_now) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on word %0d: expected %p, got %p", words_checked, exp_w, got);
        end
      end
    end
  end

  task automatic test_encoder_edges;
    begin
      send_word(FUNC_EDGE, 1'b0, 24'd0, 32'd0);
      send_word(FUNC_EDGE, 1'b1, 24'd0, 32'd0);
      send_word(FUNC_EDGE, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF);
      send_word(FUNC_CLEAR, 1'b1, 24'd0, 32'd0);
    end
  endtask

  // Presets at the extremes, with the count wrapping both ways.
  task automatic test_presets_and_wrap;
    begin
      send_word(FUNC_PRESET, 1'b0, 24'd0, 32'h7FFFFFFF);
      send_word(FUNC_EDGE, 1'b0, 24'd0, 32'd0);
      send_word(FUNC_EDGE, 1'b1, 24'd0, 32'd0);
      send_word(FUNC_PRESET, 1'b1, 24'hFFFFFF, 32'h80000000);
      send_word(FUNC_EDGE, 1'b1, 24'd0, 32'd0);
    end
  endtask

  task automatic test_ticks_directed;
    begin
      // Zero error: bridge inputs off, reached set, then cleared.
      write_all(32'h0001_0000, 32'd0, 32'd0, 32'd5, 10'd0, 10'd255, 1'b1);
      send_word(FUNC_PRESET, 1'b0, 24'd0, 32'd5);
      send_word(FUNC_TICK, 1'b0, 24'd1000, 32'd0);
      send_word(FUNC_CLEAR, 1'b0, 24'd0, 32'd0);
      // Zero elapsed time and the largest one, with full-scale gains.
      write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 10'd1023, 10'd1023, 1'b0);
      send_word(FUNC_TICK, 1'b0, 24'd0, 32'd0);
      send_word(FUNC_TICK, 1'b1, 24'hFFFFFF, 32'd0);
      // Floor above ceiling, wrapping error near the goal extreme.
      write_all(32'h8000_0000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 10'd600, 10'd10, 1'b1);
      send_word(FUNC_PRESET, 1'b0, 24'd0, 32'h80000000);
      send_word(FUNC_TICK, 1'b0, 24'd1, 32'd0);
      send_word(FUNC_TICK, 1'b0, 24'd50, 32'd0);
      // Small gains so the duty lands between floor and ceiling, in both directions.
      write_all(32'h0000_4000, 32'd0, 32'd0, 32'd0, 10'd20, 10'd200, 1'b0);
      send_word(FUNC_PRESET, 1'b0, 24'd0, 32'hFFFFFD00);
      send_word(FUNC_TICK, 1'b0, 24'd100, 32'd0);
      send_word(FUNC_PRESET, 1'b0, 24'd0, 32'd700);
      send_word(FUNC_TICK, 1'b0, 24'd100, 32'd0);
    end
  endtask

  function automatic logic [31:0] random_gain;
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'h0;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // Random phases: mostly encoder motion around the goal and control ticks.
  task automatic test_random(input int phases, input int per_phase);
    int k, n, r;
    logic [31:0] g;
    logic [23:0] el;
    begin
      for (k = 0; k < phases; k++) begin
        idle_en = (k % 4) != 3;
        g = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400) - 200;
        write_all(random_gain(), random_gain(), random_gain(), g,
                  $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 40)),
                  $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(100, 300)),
                  1'($urandom));
        for (n = 0; n < per_phase; n++) begin
          if (n == per_phase / 2 && k == 1) drain();
          r = $urandom_range(0, 99);
          if (r < 60) begin
            send_word(FUNC_EDGE, 1'($urandom), 24'($urandom), $urandom);
          end else if (r < 85) begin
            el = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5000));
            send_word(FUNC_TICK, 1'($urandom), el, $urandom);
          end else if (r < 93) begin
            send_word(FUNC_PRESET, 1'($urandom), 24'($urandom),
                      ($urandom_range(0, 1) == 0) ? $urandom : g + $urandom_range(0, 20) - 10);
          end else begin
            send_word(FUNC_CLEAR, 1'($urandom), 24'($urandom), $urandom);
          end
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_GAIN_P;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    sink_stall = 0;
    cycle_cnt = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    ticks_sent = 0;
    idle_en = 1'b1;
    kp = 0; ki = 0; kd = 0; goal = 0;
    duty_lo = 10'd0; duty_hi = 10'd255; sep_en = 1'b1;
    pos_cnt = 0; last_err = 0; err_sum = 0; at_goal = 1'b0;
    drv_in1 = '0; drv_in2 = '0; drv_en = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_encoder_edges();
    test_presets_and_wrap();
    test_ticks_directed();
    test_random(8, 155);

    drain();
    repeat (IDLE_WAIT) @(negedge clk_i);
    $display("Covered %0d words (%0d control ticks), %0d results checked over 12 settings,",
             words_sent, ticks_sent, words_checked);
    $display("including saturating gains, wrap, zero elapsed time and floor above ceiling.");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("encoder_pid_motor_position_controller test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_words.size());
      $display("encoder_pid_motor_position_controller test failed");
    end
    $finish;
  end

endmodule
